/* rtl/hop_count_spoof_filter_unit_defines.svh */
// Assertion helpers shared by the RTL that checks itself.
`ifndef HOP_COUNT_SPOOF_FILTER_UNIT_DEFINES_SVH
`define HOP_COUNT_SPOOF_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define HCSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define HCSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hcsf_pkg.sv */
`default_nettype none

package hcsf_pkg;

  localparam int unsigned ROWS_DEFAULT    = 64;
  localparam int unsigned COLUMNS_DEFAULT = 64;

  localparam int unsigned ROW_W     = 6;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [COUNT_W-1:0] UNKNOWN_COUNT  = 8'd255;
  localparam logic [COUNT_W-1:0] DIFF_RESET     = 8'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_BAND_LO  = 8'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_BAND_HI  = 8'd128;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP      = 8'd255;
  localparam logic [LIMIT_W-1:0] LIMIT_NONE     = 8'd0;

  localparam logic [VERDICT_W-1:0] VERDICT_LEARNED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MATCH   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SPOOF   = 2'd2;

  // Counts derived in the front end and carried to the back end.
  typedef struct packed {
    logic [COUNT_W-1:0] computed;
    logic [COUNT_W-1:0] learned;
  } count_pair_t;

  // Map a hop limit onto a hop count against the usual initial values.
  function automatic logic [COUNT_W-1:0] limit_to_count(input logic [LIMIT_W-1:0] lim);
    logic [COUNT_W-1:0] cnt;
    if (lim == LIMIT_NONE) begin
      cnt = UNKNOWN_COUNT;
    end else if (lim <= LIMIT_BAND_LO) begin
      cnt = LIMIT_BAND_LO - lim;
    end else if (lim <= LIMIT_BAND_HI) begin
      cnt = LIMIT_BAND_HI - lim;
    end else begin
      cnt = LIMIT_TOP - lim;
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

/* rtl/hcsf_in_if.sv */
`default_nettype none

interface hcsf_in_if;
  logic                            valid;
  logic                            ready;
  logic [hcsf_pkg::ROW_W-1:0]      row_index;
  logic [hcsf_pkg::COL_W-1:0]      column_index;
  logic [hcsf_pkg::LIMIT_W-1:0]    hop_limit;
  logic [hcsf_pkg::LIMIT_W-1:0]    probed_hop_limit;

  modport source (output valid, row_index, column_index, hop_limit, probed_hop_limit,
                  input ready);
  modport sink (input valid, row_index, column_index, hop_limit, probed_hop_limit,
                output ready);
endinterface

`default_nettype wire

/* rtl/hcsf_out_if.sv */
`default_nettype none

interface hcsf_out_if;
  logic                            valid;
  logic                            ready;
  logic [hcsf_pkg::VERDICT_W-1:0]  verdict;
  logic [hcsf_pkg::COUNT_W-1:0]    computed_hop_count;
  logic [hcsf_pkg::COUNT_W-1:0]    stored_hop_count;

  modport source (output valid, verdict, computed_hop_count, stored_hop_count,
                  input ready);
  modport sink (input valid, verdict, computed_hop_count, stored_hop_count,
                output ready);
endinterface

`default_nettype wire

/* rtl/hcsf_front.sv */
`default_nettype none

module hcsf_front #(
  parameter int unsigned ROWS    = hcsf_pkg::ROWS_DEFAULT,
  parameter int unsigned COLUMNS = hcsf_pkg::COLUMNS_DEFAULT
) (
  hcsf_in_if.sink pkt,
  input  logic    clear_busy,
  input  logic    q_full,
  output logic    q_push,
  output logic [((ROWS * COLUMNS > 1) ? $clog2(ROWS * COLUMNS) : 1)
                + $bits(hcsf_pkg::count_pair_t) - 1:0] q_push_data
);

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ROW_N  = 2 ** hcsf_pkg::ROW_W;
  localparam int unsigned COL_N  = 2 ** hcsf_pkg::COL_W;

  logic [hcsf_pkg::ROW_W-1:0] row_mod_tab [ROW_N];
  logic [hcsf_pkg::COL_W-1:0] col_mod_tab [COL_N];
  logic [hcsf_pkg::ROW_W-1:0] row_mod;
  logic [hcsf_pkg::COL_W-1:0] col_mod;
  logic [ADDR_W-1:0]          cell_addr;
  hcsf_pkg::count_pair_t      counts;

  // Fold indices that run past the table back into range.
  for (genvar i = 0; i < ROW_N; i++) begin : g_row_tab
    localparam int unsigned RowMod = i % ROWS;
    assign row_mod_tab[i] = hcsf_pkg::ROW_W'(RowMod);
  end

  for (genvar j = 0; j < COL_N; j++) begin : g_col_tab
    localparam int unsigned ColMod = j % COLUMNS;
    assign col_mod_tab[j] = hcsf_pkg::COL_W'(ColMod);
  end

  assign row_mod   = row_mod_tab[pkt.row_index];
  assign col_mod   = col_mod_tab[pkt.column_index];
  assign cell_addr = ADDR_W'(row_mod) * ADDR_W'(COLUMNS) + ADDR_W'(col_mod);

  assign counts.computed = hcsf_pkg::limit_to_count(pkt.hop_limit);
  assign counts.learned  = hcsf_pkg::limit_to_count(pkt.probed_hop_limit);

  // Hold off words while the table is being cleared or the queue is full.
  assign pkt.ready   = !q_full && !clear_busy;
  assign q_push      = pkt.valid && pkt.ready;
  assign q_push_data = {cell_addr, counts};

endmodule

`default_nettype wire

/* rtl/hcsf_queue.sv */
`default_nettype none

module hcsf_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/hcsf_back.sv */
`default_nettype none

module hcsf_back #(
  parameter int unsigned ROWS    = hcsf_pkg::ROWS_DEFAULT,
  parameter int unsigned COLUMNS = hcsf_pkg::COLUMNS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hcsf_pkg::COUNT_W-1:0] allowed_difference,
  input  logic                         q_empty,
  input  logic [((ROWS * COLUMNS > 1) ? $clog2(ROWS * COLUMNS) : 1)
                + $bits(hcsf_pkg::count_pair_t) - 1:0] q_data,
  output logic                         q_pop,
  output logic                         clear_busy,
  hcsf_out_if.source                   res
);

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $bits(hcsf_pkg::count_pair_t);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [hcsf_pkg::COUNT_W-1:0]   table_mem [DEPTH];

  logic [1:0]                     state;
  logic [ADDR_W-1:0]              clr_addr;
  logic [ADDR_W-1:0]              item_addr;
  hcsf_pkg::count_pair_t          item_cnt;
  logic [hcsf_pkg::COUNT_W-1:0]   rd_data;
  logic                           out_valid;
  logic [hcsf_pkg::VERDICT_W-1:0] out_verdict;
  logic [hcsf_pkg::COUNT_W-1:0]   out_computed;
  logic [hcsf_pkg::COUNT_W-1:0]   out_stored;

  logic [ADDR_W-1:0]              q_addr;
  hcsf_pkg::count_pair_t          q_cnt;
  logic [hcsf_pkg::COUNT_W-1:0]   diff;
  logic                           eval_go;
  logic                           upd;
  logic [hcsf_pkg::COUNT_W-1:0]   upd_val;
  logic [hcsf_pkg::VERDICT_W-1:0] verdict;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_wa;
  logic [hcsf_pkg::COUNT_W-1:0]   mem_wd;

  assign q_addr = q_data[ADDR_W + CNT_W - 1:CNT_W];
  assign q_cnt  = q_data[CNT_W-1:0];

  assign clear_busy = (state == ST_CLEAR);
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign eval_go    = (state == ST_EVAL) && (!out_valid || res.ready);

  assign diff = (rd_data >= item_cnt.computed) ? rd_data - item_cnt.computed
                                               : item_cnt.computed - rd_data;

  // Learn an unknown cell, refresh a matching one, leave a suspect one alone.
  always_comb begin
    if (rd_data == hcsf_pkg::UNKNOWN_COUNT) begin
      verdict = hcsf_pkg::VERDICT_LEARNED;
      upd     = 1'b1;
      upd_val = item_cnt.learned;
    end else if (diff <= allowed_difference) begin
      verdict = hcsf_pkg::VERDICT_MATCH;
      upd     = 1'b1;
      upd_val = item_cnt.computed;
    end else begin
      verdict = hcsf_pkg::VERDICT_SPOOF;
      upd     = 1'b0;
      upd_val = item_cnt.computed;
    end
  end

  assign mem_we = clear_busy || (eval_go && upd);
  assign mem_wa = clear_busy ? clr_addr : item_addr;
  assign mem_wd = clear_busy ? hcsf_pkg::UNKNOWN_COUNT : upd_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data <= table_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (eval_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_addr <= q_addr;
      item_cnt  <= q_cnt;
    end
    if (eval_go) begin
      out_verdict  <= verdict;
      out_computed <= item_cnt.computed;
      out_stored   <= rd_data;
    end
  end

  assign res.valid              = out_valid;
  assign res.verdict            = out_verdict;
  assign res.computed_hop_count = out_computed;
  assign res.stored_hop_count   = out_stored;

endmodule

`default_nettype wire

/* rtl/hop_count_spoof_filter_unit.sv */
// Channel  Dir  Word contents
// -------  ---  ----------------------------------------------------------
// pkt      in   row_index, column_index, hop_limit, probed_hop_limit
// res      out  verdict, computed_hop_count, stored_hop_count
// cfg      in   cfg_wr_en / cfg_wr_data -> allowed_difference
//
// Each word passes two back-end states: ST_IDLE pops it and reads its table
// cell, ST_EVAL decides the verdict and, unless it is a spoof, writes the cell
// back over the single write port. ST_EVAL waits while res holds an untaken
// word, and the next word is popped only once the last one has left ST_EVAL.
// After reset the back end clears all ROWS*COLUMNS cells to unknown, one per
// cycle; pkt.ready stays low until the clear is done.
// A two-word queue parts front and back; res holds its word until taken.
`default_nettype none

module hop_count_spoof_filter_unit #(
  parameter int unsigned ROWS    = hcsf_pkg::ROWS_DEFAULT,
  parameter int unsigned COLUMNS = hcsf_pkg::COLUMNS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [hcsf_pkg::COUNT_W-1:0] cfg_wr_data,
  hcsf_in_if.sink                      pkt,
  hcsf_out_if.source                   res
);

`include "hop_count_spoof_filter_unit_defines.svh"

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned Q_W    = ADDR_W + $bits(hcsf_pkg::count_pair_t);

  logic [hcsf_pkg::COUNT_W-1:0] allowed_difference;
  logic                         clear_busy;
  logic                         q_push;
  logic [Q_W-1:0]               q_push_data;
  logic                         q_full;
  logic                         q_pop;
  logic [Q_W-1:0]               q_data;
  logic                         q_empty;

  // Hold the tolerance; write it only while no word is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_difference <= hcsf_pkg::DIFF_RESET;
    end else if (cfg_wr_en) begin
      allowed_difference <= cfg_wr_data;
    end
  end

  // Front end: fold indices into range, form the cell address, convert limits.
  hcsf_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .pkt         (pkt),
    .clear_busy  (clear_busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Decouple the two ends so each can stall on its own.
  hcsf_queue #(
    .W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: own the table, clear it after reset, read, judge and update.
  hcsf_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .allowed_difference (allowed_difference),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .clear_busy         (clear_busy),
    .res                (res)
  );

  // No word may enter while the table still holds stale contents.
  `HCSF_ASSERT_IMP(a_no_accept_in_clear, clk, rst, clear_busy, !pkt.ready, "word taken during table clear")

  // A learned verdict comes only from an unknown cell, the others never do.
  `HCSF_ASSERT_IMP(a_learn_needs_unknown, clk, rst, res.valid && (res.verdict == hcsf_pkg::VERDICT_LEARNED), res.stored_hop_count == hcsf_pkg::UNKNOWN_COUNT, "learned verdict on a known cell")

  `HCSF_ASSERT_IMP(a_known_not_learned, clk, rst, res.valid && (res.verdict != hcsf_pkg::VERDICT_LEARNED), (res.stored_hop_count != hcsf_pkg::UNKNOWN_COUNT) && ((res.verdict == hcsf_pkg::VERDICT_MATCH) || (res.verdict == hcsf_pkg::VERDICT_SPOOF)), "bad verdict for a known cell")

  // An accepted word must be visible in the queue on the next cycle.
  `HCSF_ASSERT_NEXT(a_push_lands, clk, rst, pkt.valid && pkt.ready, !q_empty, "accepted word lost before the queue")

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ROWS       = hcsf_pkg::ROWS_DEFAULT;
  localparam int unsigned COLUMNS    = hcsf_pkg::COLUMNS_DEFAULT;
  localparam int unsigned CELLS      = ROWS * COLUMNS;
  localparam int unsigned CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned POOL_SIZE  = 16;
  // Covers the clearing pass (one cell per cycle) plus about 1300 words with idling on
  // both sides, several times over.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result word as the block should return it.
  typedef struct packed {
    logic [hcsf_pkg::VERDICT_W-1:0] verdict;
    logic [hcsf_pkg::COUNT_W-1:0]   computed_hop_count;
    logic [hcsf_pkg::COUNT_W-1:0]   stored_hop_count;
  } filter_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [hcsf_pkg::COUNT_W-1:0]  cfg_wr_data = '0;

  hcsf_in_if  pkt_ch ();
  hcsf_out_if res_ch ();

  hop_count_spoof_filter_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pkt         (pkt_ch),
    .res         (res_ch)
  );

  always #1 clk = ~clk;

  // Predictor state: a private copy of the hop count table and the threshold.
  logic [hcsf_pkg::COUNT_W-1:0] hop_table [CELLS];
  logic [hcsf_pkg::COUNT_W-1:0] allowed_diff;

  // Results owed by the block, oldest first.
  filter_result_t results_due[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle odds in % (source per word, sink per ready pick); sink_hold_cycles forces a long stall.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_cycles = 0;

  // Cells revisited by the random part, each with its usual hop limit.
  logic [hcsf_pkg::ROW_W-1:0]   pool_row  [POOL_SIZE];
  logic [hcsf_pkg::COL_W-1:0]   pool_col  [POOL_SIZE];
  logic [hcsf_pkg::LIMIT_W-1:0] pool_limit[POOL_SIZE];

  // Hop limit -> hop count: distance below the nearest usual initial value at or above it.
  function automatic logic [hcsf_pkg::COUNT_W-1:0] hop_count_from_limit(
      input logic [hcsf_pkg::LIMIT_W-1:0] lim);
    logic [hcsf_pkg::LIMIT_W-1:0] ceiling;
    ceiling = (lim <= hcsf_pkg::LIMIT_BAND_LO) ? hcsf_pkg::LIMIT_BAND_LO :
              (lim <= hcsf_pkg::LIMIT_BAND_HI) ? hcsf_pkg::LIMIT_BAND_HI : hcsf_pkg::LIMIT_TOP;
    return (lim == hcsf_pkg::LIMIT_NONE) ? hcsf_pkg::UNKNOWN_COUNT : ceiling - lim;
  endfunction

  // Judge one accepted word against the table, update the cell and queue the result.
  task automatic predict_filter_result(input logic [hcsf_pkg::ROW_W-1:0] row,
                                       input logic [hcsf_pkg::COL_W-1:0] col,
                                       input logic [hcsf_pkg::LIMIT_W-1:0] lim,
                                       input logic [hcsf_pkg::LIMIT_W-1:0] probed);
    logic [CELL_W-1:0] cell_idx;
    int                gap;
    filter_result_t    want;
    cell_idx = CELL_W'((int'(row) % ROWS) * COLUMNS + (int'(col) % COLUMNS));
    want.stored_hop_count   = hop_table[cell_idx];
    want.computed_hop_count = hop_count_from_limit(lim);
    gap = int'(want.stored_hop_count) - int'(want.computed_hop_count);
    if (gap < 0) gap = -gap;
    if (want.stored_hop_count == hcsf_pkg::UNKNOWN_COUNT) begin
      // Learn the cell from the probe; a probe of 0 leaves it unknown.
      hop_table[cell_idx] = hop_count_from_limit(probed);
      want.verdict = hcsf_pkg::VERDICT_LEARNED;
    end else if (gap <= int'(allowed_diff)) begin
      hop_table[cell_idx] = want.computed_hop_count;
      want.verdict = hcsf_pkg::VERDICT_MATCH;
    end else begin
      want.verdict = hcsf_pkg::VERDICT_SPOOF;
    end
    results_due.push_back(want);
  endtask

  // Offer one word at a falling edge, hold it until the block takes it.
  task automatic send_packet(input logic [hcsf_pkg::ROW_W-1:0] row,
                             input logic [hcsf_pkg::COL_W-1:0] col,
                             input logic [hcsf_pkg::LIMIT_W-1:0] lim,
                             input logic [hcsf_pkg::LIMIT_W-1:0] probed);
    int unsigned gap;
    gap = (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      pkt_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_ch.valid            = 1'b1;
    pkt_ch.row_index        = row;
    pkt_ch.column_index     = col;
    pkt_ch.hop_limit        = lim;
    pkt_ch.probed_hop_limit = probed;
    do @(posedge clk); while (!pkt_ch.ready);
    predict_filter_result(row, col, lim, probed);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    pkt_ch.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Write the threshold only with the block idle; the predictor follows at once.
  task automatic write_allowed_difference(input logic [hcsf_pkg::COUNT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    allowed_diff = value;
  endtask

  // Learning from the probe, including a probe that keeps the cell unknown,
  // at the table corners and at every hop limit band edge.
  task automatic test_learning();
    send_packet(6'd0,  6'd0,  8'd0,   8'd0);    // probe 0: cell stays unknown
    send_packet(6'd0,  6'd0,  8'd255, 8'd64);   // learns again, stores 0
    send_packet(6'd0,  6'd0,  8'd1,   8'd1);    // far off: spoof
    send_packet(6'd63, 6'd63, 8'd64,  8'd1);
    send_packet(6'd63, 6'd63, 8'd65,  8'd0);
    send_packet(6'd0,  6'd63, 8'd128, 8'd129);
    send_packet(6'd0,  6'd63, 8'd129, 8'd0);
    send_packet(6'd63, 6'd0,  8'd200, 8'd255);
  endtask

  // Edges of the default window: a difference of exactly the threshold passes.
  task automatic test_match_window();
    send_packet(6'd5, 6'd9, 8'd77, 8'd60);      // learn count 4
    send_packet(6'd5, 6'd9, 8'd62, 8'd0);       // diff 2: match
    send_packet(6'd5, 6'd9, 8'd59, 8'd0);       // diff 3: spoof
    send_packet(6'd5, 6'd9, 8'd61, 8'd0);       // diff 1: match
  endtask

  // Threshold at both extremes, and an accepted count of 255 that unlearns a cell.
  task automatic test_difference_extremes();
    write_allowed_difference(8'd0);
    send_packet(6'd5, 6'd9, 8'd61, 8'd0);       // exact: match
    send_packet(6'd5, 6'd9, 8'd60, 8'd0);       // off by one: spoof
    write_allowed_difference(8'd255);
    send_packet(6'd5, 6'd9, 8'd0,   8'd0);      // count 255 accepted, cell unknown again
    send_packet(6'd5, 6'd9, 8'd100, 8'd70);     // learns count 58
    send_packet(6'd5, 6'd9, 8'd255, 8'd0);      // count 0 within 255: match
    write_allowed_difference(hcsf_pkg::DIFF_RESET);
  endtask

  task automatic seed_cell_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_row[i]   = hcsf_pkg::ROW_W'($urandom);
      pool_col[i]   = hcsf_pkg::COL_W'($urandom);
      pool_limit[i] = hcsf_pkg::LIMIT_W'($urandom);
    end
  endtask

  // Mostly revisit a few cells with hop limits near their usual value, so
  // learning, matching and spoofing all occur; a quarter of the words are noise.
  task automatic send_random_packets(input int unsigned count);
    int unsigned                  pick;
    logic [hcsf_pkg::LIMIT_W-1:0] lim;
    logic [hcsf_pkg::LIMIT_W-1:0] probed;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_packet(hcsf_pkg::ROW_W'($urandom), hcsf_pkg::COL_W'($urandom),
                    hcsf_pkg::LIMIT_W'($urandom), hcsf_pkg::LIMIT_W'($urandom));
      end else begin
        pick   = $urandom_range(0, POOL_SIZE - 1);
        lim    = pool_limit[pick] + hcsf_pkg::LIMIT_W'($urandom_range(0, 6))
                 - hcsf_pkg::LIMIT_W'(3);
        probed = ($urandom_range(0, 3) == 0) ? hcsf_pkg::LIMIT_W'($urandom)
                                             : pool_limit[pick];
        send_packet(pool_row[pick], pool_col[pick], lim, probed);
      end
    end
  endtask

  // Stall the result side long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    src_idle_pct     = 0;
    sink_hold_cycles = 120;
    seed_cell_pool();
    send_random_packets(20);
  endtask

  // Random phases over several thresholds and idling mixes.
  task automatic test_random_traffic();
    src_idle_pct = 20; sink_idle_pct = 20;
    seed_cell_pool();
    send_random_packets(260);
    write_allowed_difference(hcsf_pkg::COUNT_W'($urandom_range(3, 254)));
    src_idle_pct = 0;  sink_idle_pct = 30;
    send_random_packets(260);
    write_allowed_difference(8'd0);
    src_idle_pct = 30; sink_idle_pct = 0;
    seed_cell_pool();
    send_random_packets(260);
    write_allowed_difference(8'd255);
    src_idle_pct = 15; sink_idle_pct = 15;
    send_random_packets(260);
    // Finish with no idling on either side.
    write_allowed_difference(hcsf_pkg::DIFF_RESET);
    src_idle_pct = 0;  sink_idle_pct = 0;
    seed_cell_pool();
    send_random_packets(260);
  endtask

  // Result side: hold ready low during a forced stall or a random burst.
  initial begin
    int unsigned burst;
    burst = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready = 1'b0;
      end else if (sink_hold_cycles != 0) begin
        res_ch.ready = 1'b0;
        sink_hold_cycles--;
      end else if (burst != 0) begin
        res_ch.ready = 1'b0;
        burst--;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        res_ch.ready = 1'b0;
        burst = $urandom_range(0, 7);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Compare each taken result word with the oldest one owed.
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result word: verdict %0d computed %0d stored %0d",
               res_ch.verdict, res_ch.computed_hop_count, res_ch.stored_hop_count);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (res_ch.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
          error_count++;
        end
        if (res_ch.computed_hop_count !== want.computed_hop_count) begin
          $error("computed_hop_count: expected %0d, got %0d",
                 want.computed_hop_count, res_ch.computed_hop_count);
          error_count++;
        end
        if (res_ch.stored_hop_count !== want.stored_hop_count) begin
          $error("stored_hop_count: expected %0d, got %0d",
                 want.stored_hop_count, res_ch.stored_hop_count);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still owed", cycle_count,
             results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pkt_ch.valid            = 1'b0;
    pkt_ch.row_index        = '0;
    pkt_ch.column_index     = '0;
    pkt_ch.hop_limit        = '0;
    pkt_ch.probed_hop_limit = '0;
    foreach (hop_table[i]) hop_table[i] = hcsf_pkg::UNKNOWN_COUNT;
    allowed_diff = hcsf_pkg::DIFF_RESET;

    // Hold reset, then release it at a falling edge; the block then clears its table on its own.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 25; sink_idle_pct = 25;
    test_learning();
    test_match_window();
    test_difference_extremes();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
